### rtl/core/rcat_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the rectangle corner transform.
// No dependencies; every other file in rtl/core uses this package.
package rcat_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int STEPS_PER_STAGE = 4;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

    typedef logic signed [26:0] cxy_t;
    typedef logic signed [24:0] cz_t;
    typedef logic signed [56:0] prod_t;

    // Start value of x, the inverse CORDIC gain in Q.24.
    localparam cxy_t CORDIC_GAIN = 27'sd10188014;

    // Arctangent of 2^-i in units of a turn / 2^24.
    localparam cz_t ATAN_TURN24 [CORDIC_STEPS] = '{
        25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
        25'sd166669,  25'sd83416,   25'sd41718,  25'sd20860,
        25'sd10430,   25'sd5215,    25'sd2608,   25'sd1304,
        25'sd652,     25'sd326,     25'sd163,    25'sd81
    };

    localparam logic [1:0] CORNER_LT = 2'd0;
    localparam logic [1:0] CORNER_LB = 2'd1;
    localparam logic [1:0] CORNER_RT = 2'd2;
    localparam logic [1:0] CORNER_RB = 2'd3;

    localparam logic signed [31:0] Q24_MIN = -32'sd8388608;
    localparam logic signed [31:0] Q24_MAX = 32'sd8388607;

    typedef struct packed {
        logic [23:0]        width;
        logic [23:0]        height;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
    } item_t;

    typedef struct packed {
        cxy_t       x;
        cxy_t       y;
        cz_t        z;
        logic [1:0] quad;
        item_t      item;
    } cordic_t;

    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
        item_t              item;
    } trig_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        item_t              item;
    } mat_t;

    typedef struct packed {
        prod_t              p_wc;
        prod_t              p_hs;
        prod_t              p_ws;
        prod_t              p_hc;
        logic [23:0]        width;
        logic [23:0]        height;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
    } corner_src_t;

    // Four rotation-mode CORDIC iterations starting at step base.
    function automatic cordic_t cordic_group(input cordic_t cin, input int base);
        cordic_t t;
        cxy_t    dx;
        cxy_t    dy;
        t = cin;
        for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            dx = t.y >>> (base + j);
            dy = t.x >>> (base + j);
            if (!t.z[24]) begin
                t.x = t.x - dx;
                t.y = t.y + dy;
                t.z = t.z - ATAN_TURN24[base + j];
            end else begin
                t.x = t.x + dx;
                t.y = t.y - dy;
                t.z = t.z + ATAN_TURN24[base + j];
            end
        end
        return t;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v < Q24_MIN) begin
            r = Q24_MIN[23:0];
        end else if (v > Q24_MAX) begin
            r = Q24_MAX[23:0];
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/rcat_cordic.sv
`timescale 1ns / 1ps
// Pipelined sine/cosine: four CORDIC stages of four iterations, then a round stage.
// Depends on rcat_pkg.
module rcat_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [15:0]     angle,
    input  rcat_pkg::item_t item,
    output logic            out_valid,
    input  logic            out_stall,
    output rcat_pkg::trig_t trig
);
    import rcat_pkg::*;

    localparam int NV = CORDIC_STAGES + 1;

    cordic_t          stage_reg  [CORDIC_STAGES];
    cordic_t          stage_next [CORDIC_STAGES];
    cordic_t          seed;
    trig_t            trig_reg;
    trig_t            trig_next;
    logic [NV-1:0]    vld_reg;
    logic [NV-1:0]    go;
    cxy_t             xr;
    cxy_t             yr;
    logic signed [15:0] xc;
    logic signed [15:0] yc;
    cordic_t          last_st;

    // A stage can load when it is empty or its content moves on.
    always_comb
    begin
        go[NV-1] = !vld_reg[NV-1] || !out_stall;
        for (int k = NV - 2; k >= 0; k--) begin
            go[k] = !vld_reg[k] || go[k+1];
        end
    end

    assign in_stall = !go[0];

    always_comb
    begin
        seed.x    = CORDIC_GAIN;
        seed.y    = '0;
        seed.z    = cz_t'({angle[13:0], 8'd0});
        seed.quad = angle[15:14];
        seed.item = item;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign stage_next[g] = cordic_group(seed, 0);
        end else begin : g_rest
            assign stage_next[g] = cordic_group(stage_reg[g-1], g * STEPS_PER_STAGE);
        end

        always_ff @(posedge clk)
        begin
            if (go[g]) begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    // Round Q.24 to Q.14, clamp, then fold in the quadrant.
    always_comb
    begin
        last_st = stage_reg[CORDIC_STAGES-1];
        xr = (last_st.x + 27'sd512) >>> 10;
        yr = (last_st.y + 27'sd512) >>> 10;
        if (xr > 27'sd16384) begin
            xc = 16'sd16384;
        end else if (xr < -27'sd16384) begin
            xc = -16'sd16384;
        end else begin
            xc = xr[15:0];
        end
        if (yr > 27'sd16384) begin
            yc = 16'sd16384;
        end else if (yr < -27'sd16384) begin
            yc = -16'sd16384;
        end else begin
            yc = yr[15:0];
        end
        trig_next.item = last_st.item;
        case (last_st.quad)
            2'd0:
            begin
                trig_next.cos_v = xc;
                trig_next.sin_v = yc;
            end
            2'd1:
            begin
                trig_next.cos_v = -yc;
                trig_next.sin_v = xc;
            end
            2'd2:
            begin
                trig_next.cos_v = -xc;
                trig_next.sin_v = -yc;
            end
            default:
            begin
                trig_next.cos_v = yc;
                trig_next.sin_v = -xc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (go[NV-1]) begin
            trig_reg <= trig_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            if (go[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NV; k++) begin
                if (go[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[NV-1];
    assign trig      = trig_reg;

endmodule

### rtl/core/rcat_matrix.sv
`timescale 1ns / 1ps
// Two pipeline stages: scale times sin/cos, then width and height times matrix term.
// Depends on rcat_pkg.
module rcat_matrix (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rcat_pkg::trig_t       trig,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rcat_pkg::corner_src_t src
);
    import rcat_pkg::*;

    mat_t        mat_reg;
    mat_t        mat_next;
    corner_src_t src_reg;
    corner_src_t src_next;
    logic        mat_vld_reg;
    logic        src_vld_reg;
    logic        go_mat;
    logic        go_src;
    logic signed [24:0] w_s;
    logic signed [24:0] h_s;

    assign go_src   = !src_vld_reg || !out_stall;
    assign go_mat   = !mat_vld_reg || go_src;
    assign in_stall = !go_mat;

    always_comb
    begin
        mat_next.item = trig.item;
        mat_next.m00  = trig.item.scale_x * trig.cos_v;
        mat_next.m01  = trig.item.scale_x * trig.sin_v;
        mat_next.m10  = -(trig.item.scale_y * trig.sin_v);
        mat_next.m11  = trig.item.scale_y * trig.cos_v;
    end

    assign w_s = {1'b0, mat_reg.item.width};
    assign h_s = {1'b0, mat_reg.item.height};

    always_comb
    begin
        src_next.p_wc   = w_s * mat_reg.m00;
        src_next.p_hs   = h_s * mat_reg.m10;
        src_next.p_ws   = w_s * mat_reg.m01;
        src_next.p_hc   = h_s * mat_reg.m11;
        src_next.width  = mat_reg.item.width;
        src_next.height = mat_reg.item.height;
        src_next.pos_x  = mat_reg.item.pos_x;
        src_next.pos_y  = mat_reg.item.pos_y;
    end

    always_ff @(posedge clk)
    begin
        if (go_mat) begin
            mat_reg <= mat_next;
        end
        if (go_src) begin
            src_reg <= src_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mat_vld_reg <= 1'b0;
            src_vld_reg <= 1'b0;
        end else begin
            if (go_mat) begin
                mat_vld_reg <= in_valid;
            end
            if (go_src) begin
                src_vld_reg <= mat_vld_reg;
            end
        end
    end

    assign out_valid = src_vld_reg;
    assign src       = src_reg;

endmodule

### rtl/core/rcat_corner.sv
`timescale 1ns / 1ps
// Corner sequencer and two result stages: sums, cell division and saturation.
// Depends on rcat_pkg.
module rcat_corner #(
    parameter int BLOCK_SIZE = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rcat_pkg::corner_src_t src,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            corner,
    output logic                  last,
    output logic signed [23:0]    world_x,
    output logic signed [23:0]    world_y,
    output logic signed [10:0]    cell_x,
    output logic signed [10:0]    cell_y,
    output logic signed [23:0]    box_x,
    output logic signed [23:0]    box_y
);
    import rcat_pkg::*;

    // Cell magnitudes are below 2^MAG_W; divide by multiplying with a rounded-up reciprocal.
    localparam int MAG_W   = 17;
    localparam int BS_EFF  = (BLOCK_SIZE < 1) ? 1 : BLOCK_SIZE;
    localparam int SHIFT   = MAG_W + $clog2(BS_EFF);
    localparam int RECIP_W = SHIFT + 1;
    localparam longint RECIP_L = ((64'sd1 <<< SHIFT) + BS_EFF - 1) / BS_EFF;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int Q_W     = MAG_W + 1;

    corner_src_t seq_reg;
    logic        seq_vld_reg;
    logic [1:0]  k_reg;
    logic        emit;
    logic        seq_go;
    logic        go_a;
    logic        go_b;

    logic        a_vld_reg;
    logic [1:0]  a_k_reg;
    logic signed [57:0] a_wx_reg, a_wx_next;
    logic signed [57:0] a_wy_reg, a_wy_next;
    logic [MAG_W-1:0]   a_cmx_reg, a_cmx_next;
    logic [MAG_W-1:0]   a_cmy_reg, a_cmy_next;
    logic        a_cnx_reg, a_cnx_next;
    logic        a_cny_reg, a_cny_next;
    logic signed [26:0] a_bx_reg, a_bx_next;
    logic signed [26:0] a_by_reg, a_by_next;

    logic        out_vld_reg;
    logic [1:0]  corner_reg;
    logic signed [23:0] world_x_reg, world_x_next;
    logic signed [23:0] world_y_reg, world_y_next;
    logic signed [10:0] cell_x_reg, cell_x_next;
    logic signed [10:0] cell_y_reg, cell_y_next;
    logic signed [23:0] box_x_reg, box_x_next;
    logic signed [23:0] box_y_reg, box_y_next;

    logic        right;
    logic        top;
    prod_t       tx1, ty1, tx2, ty2;
    logic signed [57:0] px_sh;
    logic signed [57:0] py_sh;
    logic signed [26:0] w27, h27, px2, py2, ex, ey, ecx, ecy, amx, amy;
    logic signed [57:0] wxr, wyr;
    logic [PROD_W-1:0]  pcx, pcy;
    logic [Q_W-1:0]     qx, qy;

    assign go_b     = !out_vld_reg || !out_stall;
    assign go_a     = !a_vld_reg || go_b;
    assign emit     = seq_vld_reg && go_a;
    assign seq_go   = !seq_vld_reg || (emit && (k_reg == CORNER_RB));
    assign in_stall = !seq_go;

    // One item is held here while its four corners go out, one per cycle unless the result stages stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_vld_reg <= 1'b0;
            k_reg       <= CORNER_LT;
        end else if (seq_go) begin
            seq_vld_reg <= in_valid;
            k_reg       <= CORNER_LT;
        end else if (emit) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_go) begin
            seq_reg <= src;
        end
    end

    always_comb
    begin
        right = k_reg[1];
        top   = !k_reg[0];
        tx1   = right ? seq_reg.p_wc : -seq_reg.p_wc;
        ty1   = top ? seq_reg.p_hs : -seq_reg.p_hs;
        tx2   = right ? seq_reg.p_ws : -seq_reg.p_ws;
        ty2   = top ? seq_reg.p_hc : -seq_reg.p_hc;
        px_sh = {{7{seq_reg.pos_x[23]}}, seq_reg.pos_x, 27'd0};
        py_sh = {{7{seq_reg.pos_y[23]}}, seq_reg.pos_y, 27'd0};
        a_wx_next = tx1 + ty1 + px_sh;
        a_wy_next = tx2 + ty2 + py_sh;

        w27 = {3'b000, seq_reg.width};
        h27 = {3'b000, seq_reg.height};
        px2 = {{2{seq_reg.pos_x[23]}}, seq_reg.pos_x, 1'b0};
        py2 = {{2{seq_reg.pos_y[23]}}, seq_reg.pos_y, 1'b0};
        ex  = px2 + (right ? w27 : -w27);
        ey  = py2 + (top ? h27 : -h27);

        // Right and top edges step back by one whole unit before the cell lookup.
        ecx = right ? ex - 27'sd512 : ex;
        ecy = top ? ey - 27'sd512 : ey;
        amx = ecx[26] ? -ecx : ecx;
        amy = ecy[26] ? -ecy : ecy;
        a_cnx_next = ecx[26];
        a_cny_next = ecy[26];
        a_cmx_next = amx[25:9];
        a_cmy_next = amy[25:9];

        a_bx_next = (ex + 27'sd1) >>> 1;
        a_by_next = (ey + 27'sd1) >>> 1;
    end

    always_ff @(posedge clk)
    begin
        if (go_a) begin
            a_k_reg   <= k_reg;
            a_wx_reg  <= a_wx_next;
            a_wy_reg  <= a_wy_next;
            a_cmx_reg <= a_cmx_next;
            a_cmy_reg <= a_cmy_next;
            a_cnx_reg <= a_cnx_next;
            a_cny_reg <= a_cny_next;
            a_bx_reg  <= a_bx_next;
            a_by_reg  <= a_by_next;
        end
    end

    always_comb
    begin
        wxr = (a_wx_reg + 58'sd67108864) >>> 27;
        wyr = (a_wy_reg + 58'sd67108864) >>> 27;
        world_x_next = sat24(wxr[31:0]);
        world_y_next = sat24(wyr[31:0]);

        pcx = a_cmx_reg * RECIP;
        pcy = a_cmy_reg * RECIP;
        qx  = pcx[SHIFT +: Q_W];
        qy  = pcy[SHIFT +: Q_W];
        if (a_cnx_reg) begin
            cell_x_next = (qx > Q_W'(1024)) ? -11'sd1024 : -qx[10:0];
        end else begin
            cell_x_next = (qx > Q_W'(1023)) ? 11'sd1023 : qx[10:0];
        end
        if (a_cny_reg) begin
            cell_y_next = (qy > Q_W'(1024)) ? -11'sd1024 : -qy[10:0];
        end else begin
            cell_y_next = (qy > Q_W'(1023)) ? 11'sd1023 : qy[10:0];
        end

        box_x_next = sat24(32'(a_bx_reg));
        box_y_next = sat24(32'(a_by_reg));
    end

    always_ff @(posedge clk)
    begin
        if (go_b) begin
            corner_reg  <= a_k_reg;
            world_x_reg <= world_x_next;
            world_y_reg <= world_y_next;
            cell_x_reg  <= cell_x_next;
            cell_y_reg  <= cell_y_next;
            box_x_reg   <= box_x_next;
            box_y_reg   <= box_y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (go_a) begin
                a_vld_reg <= emit;
            end
            if (go_b) begin
                out_vld_reg <= a_vld_reg;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign corner    = corner_reg;
    assign last      = (corner_reg == CORNER_RB);
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;
    assign box_x     = box_x_reg;
    assign box_y     = box_y_reg;

endmodule

### rtl/core/rect_corner_affine_transform_unit.sv
`timescale 1ns / 1ps
// Top level of the rectangle corner transform: CORDIC, matrix and corner pipelines.
// Depends on rcat_pkg, rcat_cordic, rcat_matrix and rcat_corner.
//
//   channel | handshake          | moves per transfer
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_stall  | one rectangle: size, scale, angle, position
//   out     | out_valid/out_stall| one corner: index, last, world, cell and box
//
// The corner sequencer sends one corner per cycle, while the result stages are not
// stalled, on the single result channel. Every stage carries a valid bit and loads
// when it is empty or its content moves on, so a stall holds data in place instead
// of dropping it. Reset clears the valid bits and the corner counter only.
module rect_corner_affine_transform_unit #(
    parameter int BLOCK_SIZE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        width,
    input  logic [23:0]        height,
    input  logic signed [15:0] scale_x,
    input  logic signed [15:0] scale_y,
    input  logic [15:0]        angle,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         corner,
    output logic               last,
    output logic signed [23:0] world_x,
    output logic signed [23:0] world_y,
    output logic signed [10:0] cell_x,
    output logic signed [10:0] cell_y,
    output logic signed [23:0] box_x,
    output logic signed [23:0] box_y
);
    import rcat_pkg::*;

    item_t       item;
    trig_t       trig;
    corner_src_t src;
    logic        trig_valid;
    logic        trig_stall;
    logic        src_valid;
    logic        src_stall;

    always_comb
    begin
        item.width   = width;
        item.height  = height;
        item.scale_x = scale_x;
        item.scale_y = scale_y;
        item.pos_x   = pos_x;
        item.pos_y   = pos_y;
    end

    rcat_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .angle     (angle),
        .item      (item),
        .out_valid (trig_valid),
        .out_stall (trig_stall),
        .trig      (trig)
    );

    rcat_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_stall  (trig_stall),
        .trig      (trig),
        .out_valid (src_valid),
        .out_stall (src_stall),
        .src       (src)
    );

    rcat_corner #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_corner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src_valid),
        .in_stall  (src_stall),
        .src       (src),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .corner    (corner),
        .last      (last),
        .world_x   (world_x),
        .world_y   (world_y),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .box_x     (box_x),
        .box_y     (box_y)
    );

endmodule

### rtl/core/rcat_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the rectangle corner transform.
// Depends on rcat_pkg; bound to rect_corner_affine_transform_unit below.
module rcat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         corner,
    input logic               last,
    input logic signed [23:0] world_x,
    input logic signed [10:0] cell_x,
    input logic signed [23:0] box_x
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corner) && $stable(world_x)
            && $stable(cell_x) && $stable(box_x))
        else $error("stalled result changed");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (corner == rcat_pkg::CORNER_RB)))
        else $error("last does not match the final corner");

    // Corners of one rectangle come out in order, so after a transfer of any
    // corner other than the last, the next shown result is the following corner.
    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && (corner != rcat_pkg::CORNER_RB)) ##1 out_valid
            |-> (corner == $past(corner) + 2'd1))
        else $error("corner sequence broken");

    // Once reset has been seen at an edge, the pipeline is empty at the next one.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind rect_corner_affine_transform_unit rcat_checker u_rcat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .corner    (corner),
    .last      (last),
    .world_x   (world_x),
    .cell_x    (cell_x),
    .box_x     (box_x)
);
